[rtl/urlqd_pkg.sv]
package urlqd_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Escape progress inside a value.
  localparam logic [1:0] ESC_NONE   = 2'd0;
  localparam logic [1:0] ESC_PCT    = 2'd1;
  localparam logic [1:0] ESC_DIGIT1 = 2'd2;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // One classified input byte: an optional key or value byte, then an optional pair end.
  typedef struct packed {
    logic       has_data;
    kind_e      data_kind;
    logic [7:0] data;
    logic       has_end;
    logic       end_valid;
    logic       end_error;
    logic       stream_end;
  } entry_t;

  // Returns {digit_ok, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

[rtl/urlqd_front.sv]
module urlqd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 push_o,
  output urlqd_pkg::entry_t    entry_o
);
  import urlqd_pkg::*;

  logic       in_value_q, in_value_d;
  logic       stopped_q, stopped_d;
  logic [1:0] esc_q, esc_d;
  logic [3:0] nibble_q, nibble_d;
  logic       err_q, err_d;

  logic       p_in_value, p_stopped, p_err;
  logic [1:0] p_esc;
  logic [3:0] p_nibble;
  logic [4:0] hex;
  logic       is_amp;

  always_comb begin
    p_in_value = in_value_q;
    p_stopped  = stopped_q;
    p_esc      = esc_q;
    p_nibble   = nibble_q;
    p_err      = err_q;
    hex        = hex_digit(data_byte_i);
    is_amp     = (data_byte_i == CHAR_AMP);

    entry_o            = '0;
    entry_o.data_kind  = KIND_KEY;
    entry_o.stream_end = last_byte_i;

    if (is_amp) begin
      entry_o.has_end = 1'b1;
    end else if (!in_value_q) begin
      if (data_byte_i == CHAR_EQUALS) begin
        p_in_value = 1'b1;
      end else begin
        entry_o.has_data = 1'b1;
        entry_o.data     = data_byte_i;
      end
    end else if (!stopped_q) begin
      if (esc_q == ESC_NONE) begin
        if (data_byte_i == CHAR_PERCENT) begin
          p_esc = ESC_PCT;
        end else if (data_byte_i == CHAR_HASH) begin
          p_stopped = 1'b1;
        end else begin
          entry_o.has_data  = 1'b1;
          entry_o.data_kind = KIND_VALUE;
          entry_o.data      = (data_byte_i == CHAR_PLUS) ? CHAR_SPACE : data_byte_i;
        end
      end else if (!hex[4]) begin
        // A bad hex digit abandons the escape and mutes the rest of the value.
        p_err     = 1'b1;
        p_stopped = 1'b1;
        p_esc     = ESC_NONE;
        p_nibble  = 4'd0;
      end else if (esc_q == ESC_PCT) begin
        p_nibble = hex[3:0];
        p_esc    = ESC_DIGIT1;
      end else begin
        entry_o.has_data  = 1'b1;
        entry_o.data_kind = KIND_VALUE;
        entry_o.data      = {nibble_q, hex[3:0]};
        p_esc             = ESC_NONE;
        p_nibble          = 4'd0;
      end
    end

    if (last_byte_i) begin
      entry_o.has_end = 1'b1;
    end
    // Pair-end flags reflect the state after this byte has been handled.
    entry_o.end_valid = p_in_value;
    entry_o.end_error = p_in_value & (p_err | (p_esc != ESC_NONE));

    if (entry_o.has_end) begin
      in_value_d = 1'b0;
      stopped_d  = 1'b0;
      esc_d      = ESC_NONE;
      nibble_d   = 4'd0;
      err_d      = 1'b0;
    end else begin
      in_value_d = p_in_value;
      stopped_d  = p_stopped;
      esc_d      = p_esc;
      nibble_d   = p_nibble;
      err_d      = p_err;
    end
  end

  assign push_o = accept_i & (entry_o.has_data | entry_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q <= 1'b0;
      stopped_q  <= 1'b0;
      esc_q      <= ESC_NONE;
      nibble_q   <= 4'd0;
      err_q      <= 1'b0;
    end else if (accept_i) begin
      in_value_q <= in_value_d;
      stopped_q  <= stopped_d;
      esc_q      <= esc_d;
      nibble_q   <= nibble_d;
      err_q      <= err_d;
    end
  end

  a_esc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q != 2'd3) else $error("escape phase holds an unused code");

  a_esc_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (esc_q != ESC_NONE) |-> (in_value_q && !stopped_q))
    else $error("escape pending outside an active value");

  a_stop_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stopped_q || err_q) |-> in_value_q)
    else $error("value stop flags set while parsing a key");

endmodule

[rtl/urlqd_fifo.sv]
module urlqd_fifo #(
  parameter int unsigned Depth = urlqd_pkg::FIFO_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  urlqd_pkg::entry_t    push_data_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output urlqd_pkg::entry_t    head_o
);
  import urlqd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("queue count beyond depth");

endmodule

[rtl/urlqd_back.sv]
module urlqd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  urlqd_pkg::entry_t    head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic                 pair_valid_o,
  output logic                 pair_error_o,
  output logic                 stream_end_o
);
  import urlqd_pkg::*;

  logic       valid_q;
  logic       data_done_q, data_done_d;
  logic       load;
  logic       take_data;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic       pv_q, pv_d, pe_q, pe_d, se_q, se_d;

  // The output register refills whenever it is empty or being drained.
  assign load      = !empty_i && (!valid_q || out_ready_i);
  assign take_data = head_i.has_data && !data_done_q;

  always_comb begin
    data_done_d = data_done_q;
    pop_o       = 1'b0;
    kind_d      = KIND_END;
    byte_d      = 8'd0;
    pv_d        = head_i.end_valid;
    pe_d        = head_i.end_error;
    se_d        = head_i.stream_end;
    if (take_data) begin
      kind_d = head_i.data_kind;
      byte_d = head_i.data;
      pv_d   = 1'b0;
      pe_d   = 1'b0;
      se_d   = head_i.stream_end & !head_i.has_end;
    end
    if (load) begin
      if (take_data && head_i.has_end) begin
        data_done_d = 1'b1;
      end else begin
        data_done_d = 1'b0;
        pop_o       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      data_done_q <= 1'b0;
    end else begin
      data_done_q <= data_done_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      pv_q   <= pv_d;
      pe_q   <= pe_d;
      se_q   <= se_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = kind_q;
  assign out_byte_o   = byte_q;
  assign pair_valid_o = pv_q;
  assign pair_error_o = pe_q;
  assign stream_end_o = se_q;

  a_half_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_done_q |-> (!empty_i && head_i.has_end))
    else $error("split entry lost from the queue head");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && se_q) |-> (kind_q == KIND_END))
    else $error("stream end marked on a non pair-end result");

  a_flags_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != KIND_END) |-> (!pv_q && !pe_q))
    else $error("pair flags set on a byte result");

endmodule

[rtl/url_query_string_decoder_unit.sv]
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------------
// input    | in_valid_i / in_ready_o   | data_byte_i, last_byte_i
// output   | out_valid_o / out_ready_i | kind_o, out_byte_o, pair_valid_o,
//          |                           | pair_error_o, stream_end_o
//
// One byte is accepted per cycle while the request queue between the parser and the
// output stage has room. The output stage delivers one result per cycle while results
// are queued and out_ready_i is high; a data byte plus a pair end gives two results.
// The first result of a byte is queued when the byte is accepted, then moves into the
// output register once it is empty or drained; it is taken while out_ready_i is high.
// Reset clears the parser state, empties the queue and clears the output valid flag.
module url_query_string_decoder_unit #(
  parameter int unsigned FifoDepth = urlqd_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       pair_valid_o,
  output logic       pair_error_o,
  output logic       stream_end_o
);
  import urlqd_pkg::*;

  logic   accept, push, pop, full, empty;
  entry_t push_entry, head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i & in_ready_o;

  urlqd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  urlqd_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  urlqd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .pair_valid_o(pair_valid_o),
    .pair_error_o(pair_error_o),
    .stream_end_o(stream_end_o)
  );

endmodule
